// File: src/hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared constants, widths and types of the HSL to RGBW converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int FULL_SCALE    = 1000;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 10;
    localparam int ONE_Q  = 1 << FRACTION_BITS;
    localparam int THIRD_Q      = ONE_Q / 3;
    localparam int TWO_THIRDS_Q = (2 * ONE_Q) / 3;

    localparam int Q_W    = FRACTION_BITS + 1;
    localparam int V_W    = FRACTION_BITS + 2;
    localparam int T_W    = FRACTION_BITS + 4;
    localparam int LVL_W  = $clog2(FULL_SCALE + 1);
    localparam int SUM_W  = LVL_W + 2;
    localparam int NUM_W  = LVL_W + SUM_W;
    localparam int DEN_W  = LVL_W + 2;

    localparam int DIV_STAGES = (LVL_W + 1) / 2;
    localparam int PRE_STAGES = 8;
    localparam int NSTG       = PRE_STAGES + DIV_STAGES + 1;

    typedef enum logic [1:0] {
        SEC_INTERP  = 2'd0,
        SEC_HOLD_V2 = 2'd1,
        SEC_HOLD_V1 = 2'd2
    } sec_mode_t;

    typedef struct packed {
        sec_mode_t                 mode;
        logic [FRACTION_BITS-1:0]  fac;
    } sect_t;

    typedef struct packed {
        logic [LVL_W-1:0] r;
        logic [LVL_W-1:0] g;
        logic [LVL_W-1:0] b;
        logic [LVL_W-1:0] mn;
        logic             grey;
        logic             dark;
    } side_t;

    function automatic sect_t sect_sel(input logic signed [T_W-1:0] t_in);
        logic signed [T_W-1:0] t;
        logic [Q_W-1:0]        tu;
        logic [Q_W+2:0]        six;
        logic [Q_W+2:0]        six_hi;
        sect_t                 res;
        t = t_in;
        if (t < 0)
        begin
            t = t + T_W'(ONE_Q);
        end
        if (t > T_W'(ONE_Q))
        begin
            t = t - T_W'(ONE_Q);
        end
        tu     = t[Q_W-1:0];
        six    = (Q_W+3)'(tu) * (Q_W+3)'(6);
        six_hi = ((Q_W+3)'(TWO_THIRDS_Q) - (Q_W+3)'(tu)) * (Q_W+3)'(6);
        res.fac  = '0;
        res.mode = SEC_HOLD_V1;
        if (six < (Q_W+3)'(ONE_Q))
        begin
            res.mode = SEC_INTERP;
            res.fac  = six[FRACTION_BITS-1:0];
        end
        else if ((Q_W+3)'(tu) * (Q_W+3)'(2) < (Q_W+3)'(ONE_Q))
        begin
            res.mode = SEC_HOLD_V2;
        end
        else if ((Q_W+3)'(tu) * (Q_W+3)'(3) < (Q_W+3)'(2 * ONE_Q))
        begin
            res.mode = SEC_INTERP;
            res.fac  = six_hi[FRACTION_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/hrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_div
// Pipelined restoring divider, two quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
module hrc_div
(
    input  logic                            clk,
    input  logic [hrc_pkg::DIV_STAGES-1:0]  en,
    input  logic [hrc_pkg::NUM_W-1:0]       num,
    input  logic [hrc_pkg::DEN_W-1:0]       den,
    input  hrc_pkg::side_t                  side_in,
    output logic [hrc_pkg::LVL_W-1:0]       quo,
    output hrc_pkg::side_t                  side_out
);

    localparam int NS  = hrc_pkg::DIV_STAGES;
    localparam int LW  = hrc_pkg::LVL_W;
    localparam int CW  = hrc_pkg::NUM_W + hrc_pkg::LVL_W;

    logic [hrc_pkg::NUM_W-1:0] rem_reg [NS];
    logic [hrc_pkg::DEN_W-1:0] den_reg [NS];
    logic [LW-1:0]             q_reg   [NS];
    hrc_pkg::side_t            side_reg[NS];

    logic [hrc_pkg::NUM_W-1:0] rem_next[NS];
    logic [LW-1:0]             q_next  [NS];

    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            rem_next[j] = (j == 0) ? num : rem_reg[(j == 0) ? 0 : j - 1];
            q_next[j]   = (j == 0) ? '0  : q_reg[(j == 0) ? 0 : j - 1];
            for (int b = 0; b < 2; b++)
            begin
                if (LW - 1 - (2 * j + b) >= 0)
                begin
                    if (CW'(rem_next[j]) >=
                        (CW'((j == 0) ? den : den_reg[(j == 0) ? 0 : j - 1])
                         << (LW - 1 - (2 * j + b))))
                    begin
                        rem_next[j] = hrc_pkg::NUM_W'(CW'(rem_next[j]) -
                            (CW'((j == 0) ? den : den_reg[(j == 0) ? 0 : j - 1])
                             << (LW - 1 - (2 * j + b))));
                        q_next[j][LW - 1 - (2 * j + b)] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                den_reg[j]  <= (j == 0) ? den : den_reg[(j == 0) ? 0 : j - 1];
                side_reg[j] <= (j == 0) ? side_in : side_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign quo      = q_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

// File: src/hsl_to_rgbw_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgbw_converter
// HSL to RGBW converter with white extraction, fixed-point pipeline.
// ----------------------------------------------------------------------------
// Takes one hue/saturation/lightness transaction per clock while not stalled
// and returns one red/green/blue/white transaction per input, in order. The
// pipeline has eight stages of scaling, sector selection, multiplies and
// min/max, five stages of the white-ratio divider and one output register.
// Throughput is one transaction per cycle; back-pressure on the output
// stalls only the stages that are full.
// ----------------------------------------------------------------------------
module hsl_to_rgbw_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // hue[15:0], saturation[31:16], lightness[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // red[9:0], green[19:10], blue[29:20], white[39:30]
);

    localparam int F   = hrc_pkg::FRACTION_BITS;
    localparam int QW  = hrc_pkg::Q_W;
    localparam int VW  = hrc_pkg::V_W;
    localparam int TW  = hrc_pkg::T_W;
    localparam int LW  = hrc_pkg::LVL_W;
    localparam int NS  = hrc_pkg::NSTG;
    localparam int YW  = hrc_pkg::IN_W + F + 1;
    localparam int CPW = VW + LW;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    // stage 0: scale inputs to fixed point
    function automatic logic [QW-1:0] scale_in(input logic [hrc_pkg::IN_W-1:0] x);
        logic [YW-1:0] y;
        logic [YW-1:0] acc;
        logic [QW-1:0] q0;
        logic [YW-1:0] rem;
        y   = YW'(x) << F;
        acc = y + (y >> 16) + (y >> 32);
        q0  = QW'(acc >> 16);
        rem = y - ((YW'(q0) << 16) - YW'(q0));
        if (rem >= YW'(65535))
        begin
            q0 = q0 + QW'(1);
        end
        return q0;
    endfunction

    logic [QW-1:0] h0_reg, s0_reg, l0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h0_reg <= scale_in(s_axis_tdata[15:0]);
            s0_reg <= scale_in(s_axis_tdata[31:16]);
            l0_reg <= scale_in(s_axis_tdata[47:32]);
        end
    end

    // stage 1: lightness times saturation
    logic [QW-1:0]   h1_reg, s1_reg, l1_reg, ls1_reg;
    logic [2*QW-1:0] ls_full;

    assign ls_full = (2*QW)'(l0_reg) * (2*QW)'(s0_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h1_reg  <= h0_reg;
            s1_reg  <= s0_reg;
            l1_reg  <= l0_reg;
            ls1_reg <= QW'(ls_full >> F);
        end
    end

    // stage 2: v1, v2 and hue sectors
    logic [VW-1:0]        v2a, v1c, v2c;
    logic signed [VW:0]   v1s;
    logic signed [TW-1:0] t_in [3];
    logic [VW-1:0]        v1_2_reg, d2_reg;
    hrc_pkg::sect_t       sec2_reg [3];
    logic                 grey2_reg;

    always_comb
    begin
        if (l1_reg < QW'(hrc_pkg::ONE_Q / 2))
        begin
            v2a = VW'(l1_reg) + VW'(ls1_reg);
        end
        else
        begin
            v2a = VW'(l1_reg) + VW'(s1_reg) - VW'(ls1_reg);
        end
        v1s = $signed((VW+1)'(l1_reg) << 1) - $signed((VW+1)'(v2a));
        v1c = (v1s < 0) ? '0 : v1s[VW-1:0];
        v2c = (v2a < v1c) ? v1c : v2a;
        t_in[0] = $signed(TW'(h1_reg)) + $signed(TW'(hrc_pkg::THIRD_Q));
        t_in[1] = $signed(TW'(h1_reg));
        t_in[2] = $signed(TW'(h1_reg)) - $signed(TW'(hrc_pkg::THIRD_Q));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            v1_2_reg  <= v1c;
            d2_reg    <= v2c - v1c;
            grey2_reg <= (s1_reg == '0);
            for (int c = 0; c < 3; c++)
            begin
                sec2_reg[c] <= hrc_pkg::sect_sel(t_in[c]);
            end
        end
    end

    // stage 3: interpolation products
    logic [VW+F-1:0]   prod3_reg [3];
    logic [VW-1:0]     v1_3_reg, d3_reg;
    hrc_pkg::sec_mode_t mode3_reg [3];
    logic              grey3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            v1_3_reg  <= v1_2_reg;
            d3_reg    <= d2_reg;
            grey3_reg <= grey2_reg;
            for (int c = 0; c < 3; c++)
            begin
                prod3_reg[c] <= (VW+F)'(d2_reg) * (VW+F)'(sec2_reg[c].fac);
                mode3_reg[c] <= sec2_reg[c].mode;
            end
        end
    end

    // stage 4: channel value times full scale
    logic [VW-1:0]  ch4 [3];
    logic [CPW-1:0] cp4_reg [3];
    logic           grey4_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (mode3_reg[c])
                hrc_pkg::SEC_INTERP:  ch4[c] = v1_3_reg + VW'(prod3_reg[c] >> F);
                hrc_pkg::SEC_HOLD_V2: ch4[c] = v1_3_reg + d3_reg;
                hrc_pkg::SEC_HOLD_V1: ch4[c] = v1_3_reg;
                default:              ch4[c] = v1_3_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            grey4_reg <= grey3_reg;
            for (int c = 0; c < 3; c++)
            begin
                cp4_reg[c] <= CPW'(ch4[c]) * CPW'(hrc_pkg::FULL_SCALE);
            end
        end
    end

    // stage 5: levels
    logic [CPW-F-1:0] lv_raw [3];
    logic [LW-1:0]    lvl5_reg [3];
    logic             grey5_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lv_raw[c] = cp4_reg[c][CPW-1:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            grey5_reg <= grey4_reg;
            for (int c = 0; c < 3; c++)
            begin
                lvl5_reg[c] <= (lv_raw[c] > (CPW-F)'(hrc_pkg::FULL_SCALE)) ?
                               LW'(hrc_pkg::FULL_SCALE) : LW'(lv_raw[c]);
            end
        end
    end

    // stage 6: max, min, sum
    logic [LW-1:0]             mx6, mn6;
    logic [LW-1:0]             lvl6_reg [3];
    logic [LW-1:0]             mx6_reg, mn6_reg;
    logic [hrc_pkg::SUM_W-1:0] sum6_reg;
    logic                      grey6_reg;

    always_comb
    begin
        mx6 = (lvl5_reg[0] > lvl5_reg[1]) ? lvl5_reg[0] : lvl5_reg[1];
        if (lvl5_reg[2] > mx6)
        begin
            mx6 = lvl5_reg[2];
        end
        mn6 = (lvl5_reg[0] < lvl5_reg[1]) ? lvl5_reg[0] : lvl5_reg[1];
        if (lvl5_reg[2] < mn6)
        begin
            mn6 = lvl5_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            lvl6_reg  <= lvl5_reg;
            mx6_reg   <= mx6;
            mn6_reg   <= mn6;
            sum6_reg  <= hrc_pkg::SUM_W'(lvl5_reg[0]) + hrc_pkg::SUM_W'(lvl5_reg[1])
                         + hrc_pkg::SUM_W'(lvl5_reg[2]);
            grey6_reg <= grey5_reg;
        end
    end

    // stage 7: divider operands
    logic [hrc_pkg::NUM_W-1:0] num7_reg;
    logic [hrc_pkg::DEN_W-1:0] den7_reg;
    hrc_pkg::side_t            side7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            num7_reg       <= hrc_pkg::NUM_W'(mn6_reg) * hrc_pkg::NUM_W'(sum6_reg);
            den7_reg       <= hrc_pkg::DEN_W'(mx6_reg) * hrc_pkg::DEN_W'(3);
            side7_reg.r    <= lvl6_reg[0];
            side7_reg.g    <= lvl6_reg[1];
            side7_reg.b    <= lvl6_reg[2];
            side7_reg.mn   <= mn6_reg;
            side7_reg.grey <= grey6_reg;
            side7_reg.dark <= (mx6_reg == '0);
        end
    end

    logic [LW-1:0]  quo;
    hrc_pkg::side_t side_d;

    hrc_div u_div
    (
        .clk      (clk),
        .en       (en[hrc_pkg::PRE_STAGES +: hrc_pkg::DIV_STAGES]),
        .num      (num7_reg),
        .den      (den7_reg),
        .side_in  (side7_reg),
        .quo      (quo),
        .side_out (side_d)
    );

    // output stage: add white share, take out clamped minimum; grey inputs pass through with white zero
    logic [LW:0]                tw, wmin, wcl;
    logic [LW:0]                rt, gt, bt;
    logic [hrc_pkg::OUT_W-1:0]  r_out_reg, g_out_reg, b_out_reg, w_out_reg;

    always_comb
    begin
        tw   = side_d.dark ? '0 : (LW+1)'(quo);
        rt   = (LW+1)'(side_d.r) + tw;
        gt   = (LW+1)'(side_d.g) + tw;
        bt   = (LW+1)'(side_d.b) + tw;
        wmin = (LW+1)'(side_d.mn) + tw;
        wcl  = (wmin > (LW+1)'(hrc_pkg::FULL_SCALE)) ? (LW+1)'(hrc_pkg::FULL_SCALE) : wmin;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            if (side_d.grey)
            begin
                r_out_reg <= hrc_pkg::OUT_W'(side_d.r);
                g_out_reg <= hrc_pkg::OUT_W'(side_d.g);
                b_out_reg <= hrc_pkg::OUT_W'(side_d.b);
                w_out_reg <= '0;
            end
            else
            begin
                r_out_reg <= hrc_pkg::OUT_W'(rt - wcl);
                g_out_reg <= hrc_pkg::OUT_W'(gt - wcl);
                b_out_reg <= hrc_pkg::OUT_W'(bt - wcl);
                w_out_reg <= hrc_pkg::OUT_W'(wcl);
            end
        end
    end

    assign m_axis_tdata = {w_out_reg, b_out_reg, g_out_reg, r_out_reg};

endmodule
